// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication, overlapping, muted while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Implication into the next cycle, muted while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/ffa_pkg.sv -----
// Shared types and constants of the fixed partition fit allocator.
// No dependencies; used by ffa_scan and the top level.
package ffa_pkg;

	localparam int PARTITIONS_DEF = 8;
	localparam int SIZE_W         = 16;
	localparam int SLOT_W         = 3;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQ     = 1'b1;
	localparam logic MODE_FIRST   = 1'b0;
	localparam logic MODE_WORST   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ffa_state_t;

	// Controls from the sequencer to the table scan unit.
	typedef struct packed {
		logic load;
		logic start;
		logic grant_clr;
		logic mode;
	} ffa_ctl_t;

	// Status from the table scan unit.
	typedef struct packed {
		logic done;
		logic found;
	} ffa_sts_t;

endpackage

// ----- hw/rtl/ffa_scan.sv -----
// Partition table: size memory with registered read, free bits, scan and
// best-candidate tracking. Depends on ffa_pkg.
module ffa_scan
	import ffa_pkg::*;
#(
	parameter int PARTITIONS = PARTITIONS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ffa_ctl_t                               ctl,
	input  logic [SLOT_W-1:0]                      wr_slot,
	input  logic [SIZE_W-1:0]                      wr_size,
	input  logic [SIZE_W-1:0]                      req_amount,
	output ffa_sts_t                               sts,
	output logic [(PARTITIONS > 1 ? $clog2(PARTITIONS) : 1)-1:0] best_idx,
	output logic [SIZE_W-1:0]                      best_size
);

	localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITIONS - 1);

	logic [SIZE_W-1:0] size_mem [PARTITIONS];
	logic              free_q [PARTITIONS];

	logic              busy_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              valid_s1;
	logic              last_s1;
	logic              free_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SIZE_W-1:0] size_s1;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [SIZE_W-1:0] best_size_q;
	logic              done_q;
	logic              wr_in_range;
	logic [IDX_W-1:0]  wr_idx;
	logic              take;

	assign wr_in_range = (32'(wr_slot) < PARTITIONS);
	assign wr_idx      = IDX_W'(wr_slot);

	// Size memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.load && wr_in_range) begin
			size_mem[wr_idx] <= wr_size;
		end
		size_s1 <= size_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PARTITIONS; i++) begin
				free_q[i] <= 1'b0;
			end
		end else begin
			if (ctl.load && wr_in_range) begin
				free_q[wr_idx] <= 1'b1;
			end
			if (ctl.grant_clr) begin
				free_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Read sequencer: one entry per cycle from index zero up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
			last_s1  <= busy_q && (rd_idx_q == LAST_IDX);
			done_q   <= valid_s1 && last_s1;
			if (ctl.start) begin
				busy_q   <= 1'b1;
				rd_idx_q <= '0;
			end else if (busy_q) begin
				if (rd_idx_q == LAST_IDX) begin
					busy_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx_q;
		free_s1 <= free_q[rd_idx_q];
	end

	// First fit keeps the first entry that fits; worst fit keeps the
	// largest free entry, strict compare so a tie keeps the lower index.
	always_comb begin
		if (ctl.mode == MODE_FIRST) begin
			take = free_s1 && !found_q && (size_s1 >= req_amount);
		end else begin
			take = free_s1 && (!found_q || (size_s1 > best_size_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (valid_s1 && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && take) begin
			best_idx_q  <= idx_s1;
			best_size_q <= size_s1;
		end
	end

	assign sts.done   = done_q;
	assign sts.found  = found_q;
	assign best_idx   = best_idx_q;
	assign best_size  = best_size_q;

endmodule

// ----- hw/rtl/fixed_partition_fit_allocator.sv -----
// Fixed partition allocator, first fit or worst fit placement.
// Depends on ffa_pkg and ffa_scan.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_stall   | kind, slot_index, amount
//  out      | out_valid / out_stall | granted, granted_index, granted_size, leftover
//  cfg      | cfg_wr_en             | cfg_wr_data (fit_mode)
//
// A load gives no result; the next transaction can follow right behind it.
// A request scans the table one entry per cycle through the single read port
// of the size memory; the input stalls until the result is loaded into the
// output register, and longer while an earlier result is still stalled there.
// The result sits in an output register; a stalled result holds there while
// the next transaction is taken. Reset marks every partition as not loaded.
module fixed_partition_fit_allocator
	import ffa_pkg::*;
#(
	parameter int PARTITIONS = PARTITIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [SIZE_W-1:0] amount,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              granted,
	output logic [SLOT_W-1:0] granted_index,
	output logic [SIZE_W-1:0] granted_size,
	output logic [SIZE_W-1:0] leftover
);

	localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

	ffa_state_t        state_q, state_d;
	ffa_ctl_t          ctl;
	ffa_sts_t          sts;
	logic [IDX_W-1:0]  best_idx;
	logic [SIZE_W-1:0] best_size;
	logic              fit_mode_q;
	logic [SIZE_W-1:0] amount_q;
	logic              in_accept;
	logic              out_load;
	logic              grant;
	logic              out_valid_q;
	logic              granted_q;
	logic [SLOT_W-1:0] granted_index_q;
	logic [SIZE_W-1:0] granted_size_q;
	logic [SIZE_W-1:0] leftover_q;

	assign in_accept = in_valid && !in_stall;
	// Worst fit may hold a candidate that is too small; first fit never does.
	assign grant     = sts.found && (best_size >= amount_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
		end else if (cfg_wr_en) begin
			fit_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		out_load      = 1'b0;
		ctl.load      = 1'b0;
		ctl.start     = 1'b0;
		ctl.grant_clr = 1'b0;
		ctl.mode      = fit_mode_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (kind == KIND_REQ) begin
						ctl.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						ctl.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (sts.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// Wait for the output register to drain.
				if (!out_valid_q || !out_stall) begin
					out_load      = 1'b1;
					ctl.grant_clr = grant;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept && (kind == KIND_REQ)) begin
			amount_q <= amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			granted_q       <= grant;
			granted_index_q <= grant ? SLOT_W'(best_idx) : '0;
			granted_size_q  <= grant ? best_size : '0;
			leftover_q      <= grant ? (best_size - amount_q) : '0;
		end
	end

	ffa_scan #(
		.PARTITIONS (PARTITIONS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.wr_slot    (slot_index),
		.wr_size    (amount),
		.req_amount (amount_q),
		.sts        (sts),
		.best_idx   (best_idx),
		.best_size  (best_size)
	);

	assign out_valid     = out_valid_q;
	assign granted       = granted_q;
	assign granted_index = granted_index_q;
	assign granted_size  = granted_size_q;
	assign leftover      = leftover_q;

endmodule

// ----- hw/rtl/ffa_checker.sv -----
// Port-level checker for the fixed partition fit allocator, bound to the top.
// Depends on ffa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffa_checker
	import ffa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              kind,
	input logic              out_valid,
	input logic              out_stall,
	input logic              granted,
	input logic [SLOT_W-1:0] granted_index,
	input logic [SIZE_W-1:0] granted_size,
	input logic [SIZE_W-1:0] leftover
);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted) && $stable(granted_index) && $stable(granted_size) && $stable(leftover), "stalled result changed")
	`ASSERT_IMPL(a_deny_zero, out_valid && !granted, (granted_index == '0) && (granted_size == '0) && (leftover == '0), "denied result has nonzero fields")
	`ASSERT_IMPL(a_leftover_fits, out_valid && granted, leftover <= granted_size, "leftover exceeds granted size")
	`ASSERT_NEXT(a_req_busy, in_valid && !in_stall && (kind == KIND_REQ), in_stall, "request transaction did not stall input")

endmodule

bind fixed_partition_fit_allocator ffa_checker u_ffa_checker (.*);
